/* design/assert_macros.svh */
// Assertion macros shared by the timestamped frame ring RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TFR_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("timestamped frame ring: invariant violated");

// An antecedent that implies a consequent in the same cycle.
`define TFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timestamped frame ring: implication violated");

`endif

/* design/tfr_pkg.sv */
// Shared types, constants and codes for the timestamped frame ring.
// No dependencies; tfr_alu and the core refer to it by scoped names.
`default_nettype none

package tfr_pkg;

	// Ring geometry.
	localparam int NODES       = 128;
	localparam int FRAMES      = 512;
	localparam int NODE_W      = $clog2(NODES);
	localparam int FRAME_W     = $clog2(FRAMES);
	localparam int FILL_W      = $clog2(FRAMES + 1);
	localparam int STEP_W      = $clog2(NODES + 1);
	localparam int STORE_DEPTH = NODES * FRAMES;
	localparam int STORE_AW    = NODE_W + FRAME_W;

	// Field widths.
	localparam int SAMPLE_W = 32;
	localparam int STAMP_W  = 40;
	localparam int TIMER_W  = 32;
	localparam int ALU_W    = STAMP_W + 1;

	// Request codes.
	localparam logic [2:0] REQ_SAMPLE = 3'd0;
	localparam logic [2:0] REQ_CLOSE  = 3'd1;
	localparam logic [2:0] REQ_TICK   = 3'd2;
	localparam logic [2:0] REQ_TAKE   = 3'd3;
	localparam logic [2:0] REQ_READ   = 3'd4;

	// Reply kinds.
	localparam logic KIND_TAKE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [SAMPLE_W-1:0] first_value;
		logic [SAMPLE_W-1:0] second_value;
		logic                is_mono;
		logic [STAMP_W-1:0]  stamp;
		logic [STAMP_W-1:0]  delay;
		logic [6:0]          node_select;
		logic [8:0]          frame_select;
	} req_t;

	typedef struct packed {
		logic                reply_kind;
		logic [6:0]          out_node;
		logic [STAMP_W-1:0]  out_stamp;
		logic [SAMPLE_W-1:0] out_left;
		logic [SAMPLE_W-1:0] out_right;
	} rsp_t;

	// Operation handed to the shared adder.
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_CLOSE,
		ST_TICK,
		ST_TGT,
		ST_TK_RD,
		ST_TK_CMP,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_REPLY
	} state_t;

	// Successor of a node index around the ring.
	function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] r;
		if (n == NODE_W'(NODES - 1)) begin
			r = '0;
		end else begin
			r = n + NODE_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/tfr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module tfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* design/tfr_alu.sv */
// Shared add/subtract unit used by the close, tick, target and take-compare steps of the ring sequencer.
// Depends on tfr_pkg for the operand width and the request and result structs.
`default_nettype none

module tfr_alu (
	input  wire tfr_pkg::alu_req_t req,
	output      tfr_pkg::alu_rsp_t rsp
);

	logic [tfr_pkg::ALU_W:0] full;
	logic [tfr_pkg::ALU_W-1:0] b_eff;

	// Subtraction is addition of the inverted operand plus one; carry set means no borrow.
	always_comb begin
		b_eff = req.sub ? ~req.b : req.b;
		full  = {1'b0, req.a} + {1'b0, b_eff} + {{tfr_pkg::ALU_W{1'b0}}, req.sub};
		rsp.sum   = full[tfr_pkg::ALU_W-1:0];
		rsp.carry = full[tfr_pkg::ALU_W];
	end

endmodule

`default_nettype wire

/* design/timestamped_frame_ring_core.sv */
// Top level of the timestamped frame ring: sequencer, node state and both stores.
// Depends on tfr_pkg, tfr_alu, tfr_ram and assert_macros.svh.
//
//   channel | direction | payload        | handshake
//   req     | in        | tfr_pkg::req_t | req_valid / req_stall
//   rsp     | out       | tfr_pkg::rsp_t | rsp_valid / rsp_stall
//
// Sample, close and tick beats go from idle to their own state and back; a read beat passes
// through its address, data and reply states. A take beat forms its target, then steps over
// at most one lap of NODES nodes, as each step waits on the registered read of the stamp memory.
// The stamp memory is not cleared: one valid flop per node marks it written since reset.
// A finished reply waits in the output register while a new request beat is taken.
// While that register is stalled, the next reply holds the sequencer in its reply state.
`default_nettype none
`include "assert_macros.svh"

module timestamped_frame_ring_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_stall,
	input  wire tfr_pkg::req_t req,
	output      logic          rsp_valid,
	input  wire logic          rsp_stall,
	output      tfr_pkg::rsp_t rsp
);

	tfr_pkg::state_t state_q, state_d;

	tfr_pkg::req_t                    req_q;
	tfr_pkg::rsp_t                    pend_q;
	tfr_pkg::rsp_t                    rsp_q;
	logic                             rsp_valid_q;
	logic [tfr_pkg::NODE_W-1:0]       wr_index_q;
	logic [tfr_pkg::NODE_W-1:0]       rd_index_q;
	logic [tfr_pkg::FILL_W-1:0]       fill_count_q;
	logic [tfr_pkg::STAMP_W-1:0]      time_base_q;
	logic [tfr_pkg::TIMER_W-1:0]      tick_timer_q;
	logic [tfr_pkg::ALU_W-1:0]        target_q;
	logic [tfr_pkg::STEP_W-1:0]       steps_q;
	logic [tfr_pkg::NODES-1:0]        stamp_vld_q;
	logic                             rd_vld_q;

	tfr_pkg::alu_req_t                alu_req;
	tfr_pkg::alu_rsp_t                alu_rsp;
	logic                             req_fire;
	logic                             out_free;
	logic                             frame_we;
	logic                             stamp_we;
	logic [tfr_pkg::NODE_W-1:0]       wr_next;
	logic [tfr_pkg::NODE_W-1:0]       nsel;
	logic [tfr_pkg::STORE_AW-1:0]     frame_wr_addr;
	logic [tfr_pkg::STORE_AW-1:0]     frame_rd_addr;
	logic [2*tfr_pkg::SAMPLE_W-1:0]   frame_wr_data;
	logic [2*tfr_pkg::SAMPLE_W-1:0]   frame_rd_data;
	logic [tfr_pkg::NODE_W-1:0]       stamp_rd_addr;
	logic [tfr_pkg::STAMP_W-1:0]      stamp_rd_data;
	logic [tfr_pkg::STAMP_W-1:0]      stamp_val;
	logic                             take_hit;
	logic                             lap_done;
	logic                             node_full;

	// Handshake helpers.
	assign req_stall = (state_q != tfr_pkg::ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Addresses and data for the two memories.
	assign wr_next       = tfr_pkg::next_node(wr_index_q);
	assign nsel          = req_q.node_select[tfr_pkg::NODE_W-1:0];
	assign node_full     = (fill_count_q == tfr_pkg::FILL_W'(tfr_pkg::FRAMES));
	assign frame_wr_addr = {wr_next, fill_count_q[tfr_pkg::FRAME_W-1:0]};
	assign frame_rd_addr = {nsel, req_q.frame_select[tfr_pkg::FRAME_W-1:0]};
	assign frame_wr_data = {req_q.first_value,
		req_q.is_mono ? req_q.first_value : req_q.second_value};
	assign stamp_rd_addr = (req_q.req_type == tfr_pkg::REQ_TAKE) ? rd_index_q : nsel;
	assign stamp_val     = rd_vld_q ? stamp_rd_data : '0;

	// Take walk decisions.
	assign lap_done = (steps_q == tfr_pkg::STEP_W'(tfr_pkg::NODES));
	assign take_hit = (stamp_val != '0) && alu_rsp.carry;

	tfr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	tfr_ram #(
		.WIDTH (2 * tfr_pkg::SAMPLE_W),
		.DEPTH (tfr_pkg::STORE_DEPTH)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (frame_we),
		.wr_addr (frame_wr_addr),
		.wr_data (frame_wr_data),
		.rd_addr (frame_rd_addr),
		.rd_data (frame_rd_data)
	);

	tfr_ram #(
		.WIDTH (tfr_pkg::STAMP_W),
		.DEPTH (tfr_pkg::NODES)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (stamp_we),
		.wr_addr (wr_next),
		.wr_data (req_q.stamp),
		.rd_addr (stamp_rd_addr),
		.rd_data (stamp_rd_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, adder operands and memory write enables.
	always_comb begin
		state_d  = state_q;
		alu_req  = '0;
		frame_we = 1'b0;
		stamp_we = 1'b0;
		case (state_q)
			tfr_pkg::ST_IDLE: begin
				if (req_fire) begin
					case (req.req_type)
						tfr_pkg::REQ_SAMPLE: state_d = tfr_pkg::ST_SAMPLE;
						tfr_pkg::REQ_CLOSE:  state_d = tfr_pkg::ST_CLOSE;
						tfr_pkg::REQ_TICK:   state_d = tfr_pkg::ST_TICK;
						tfr_pkg::REQ_TAKE:   state_d = tfr_pkg::ST_TGT;
						tfr_pkg::REQ_READ:   state_d = tfr_pkg::ST_RD_ADDR;
						default:             state_d = tfr_pkg::ST_IDLE;
					endcase
				end
			end
			tfr_pkg::ST_SAMPLE: begin
				frame_we = !node_full;
				state_d  = tfr_pkg::ST_IDLE;
			end
			tfr_pkg::ST_CLOSE: begin
				alu_req.a   = {1'b0, req_q.stamp};
				alu_req.b   = {1'b0, req_q.delay};
				alu_req.sub = 1'b1;
				stamp_we    = 1'b1;
				state_d     = tfr_pkg::ST_IDLE;
			end
			tfr_pkg::ST_TICK: begin
				alu_req.a = tfr_pkg::ALU_W'(tick_timer_q);
				alu_req.b = tfr_pkg::ALU_W'(1);
				state_d   = tfr_pkg::ST_IDLE;
			end
			tfr_pkg::ST_TGT: begin
				alu_req.a = {1'b0, time_base_q};
				alu_req.b = tfr_pkg::ALU_W'(tick_timer_q);
				state_d   = tfr_pkg::ST_TK_CMP;
			end
			tfr_pkg::ST_TK_RD: begin
				state_d = tfr_pkg::ST_TK_CMP;
			end
			tfr_pkg::ST_TK_CMP: begin
				alu_req.a   = {1'b0, stamp_val};
				alu_req.b   = target_q;
				alu_req.sub = 1'b1;
				if (lap_done || take_hit) begin
					state_d = tfr_pkg::ST_REPLY;
				end else begin
					state_d = tfr_pkg::ST_TK_RD;
				end
			end
			tfr_pkg::ST_RD_ADDR: begin
				state_d = tfr_pkg::ST_RD_DATA;
			end
			tfr_pkg::ST_RD_DATA: begin
				state_d = tfr_pkg::ST_REPLY;
			end
			tfr_pkg::ST_REPLY: begin
				if (out_free) begin
					state_d = tfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfr_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state of the ring: indices, counters, time base and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_index_q   <= '0;
			rd_index_q   <= '0;
			fill_count_q <= '0;
			time_base_q  <= '0;
			tick_timer_q <= '0;
			steps_q      <= '0;
			stamp_vld_q  <= '0;
			rd_vld_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_q <= stamp_vld_q[stamp_rd_addr];
			case (state_q)
				tfr_pkg::ST_SAMPLE: begin
					if (!node_full) begin
						fill_count_q <= fill_count_q + tfr_pkg::FILL_W'(1);
					end
				end
				tfr_pkg::ST_CLOSE: begin
					wr_index_q           <= wr_next;
					stamp_vld_q[wr_next] <= 1'b1;
					time_base_q          <= alu_rsp.carry ?
						alu_rsp.sum[tfr_pkg::STAMP_W-1:0] : '0;
					tick_timer_q         <= '0;
					fill_count_q         <= '0;
				end
				tfr_pkg::ST_TICK: begin
					if (tick_timer_q != '1) begin
						tick_timer_q <= alu_rsp.sum[tfr_pkg::TIMER_W-1:0];
					end
				end
				tfr_pkg::ST_TGT: begin
					steps_q <= '0;
				end
				tfr_pkg::ST_TK_CMP: begin
					if (!lap_done && !take_hit) begin
						rd_index_q <= tfr_pkg::next_node(rd_index_q);
						steps_q    <= steps_q + tfr_pkg::STEP_W'(1);
					end
				end
				default: begin
				end
			endcase
			// Output register: loaded from the pending reply, emptied when the beat is taken.
			if (state_q == tfr_pkg::ST_REPLY && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, target, pending reply and output beat.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (state_q == tfr_pkg::ST_TGT) begin
			target_q <= alu_rsp.sum;
		end
		if (state_q == tfr_pkg::ST_TK_CMP) begin
			pend_q.reply_kind <= tfr_pkg::KIND_TAKE;
			pend_q.out_node   <= 7'(rd_index_q);
			pend_q.out_stamp  <= stamp_val;
			pend_q.out_left   <= '0;
			pend_q.out_right  <= '0;
		end
		if (state_q == tfr_pkg::ST_RD_DATA) begin
			pend_q.reply_kind <= tfr_pkg::KIND_READ;
			pend_q.out_node   <= 7'(nsel);
			pend_q.out_stamp  <= stamp_val;
			pend_q.out_left   <= frame_rd_data[2*tfr_pkg::SAMPLE_W-1:tfr_pkg::SAMPLE_W];
			pend_q.out_right  <= frame_rd_data[tfr_pkg::SAMPLE_W-1:0];
		end
		if (state_q == tfr_pkg::ST_REPLY && out_free) begin
			rsp_q <= pend_q;
		end
	end

	// The frame count of the open node never passes the node size.
	`TFR_ASSERT_ALWAYS(a_fill_bound, fill_count_q <= tfr_pkg::FILL_W'(tfr_pkg::FRAMES))
	// The take walk never goes further than one lap.
	`TFR_ASSERT_ALWAYS(a_step_bound, steps_q <= tfr_pkg::STEP_W'(tfr_pkg::NODES))
	// A reply beat appears only when the sequencer hands one over.
	`TFR_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid_q), $past(state_q) == tfr_pkg::ST_REPLY)
	// A pending take reply names the node where the read index rests.
	`TFR_ASSERT_IMPL(a_take_node,
		state_q == tfr_pkg::ST_REPLY && pend_q.reply_kind == tfr_pkg::KIND_TAKE,
		pend_q.out_node == 7'(rd_index_q))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for timestamped_frame_ring_core: directed beats, then random traffic.
// Depends on tfr_pkg and the core; a local model of the ring predicts each reply beat that the plan does not type in.
`default_nettype none

module testbench;
	import tfr_pkg::*;

	localparam int RANDOM_BEATS = 1525;
	localparam int CALM_TAIL    = 150;
	localparam int BURST_AT     = 500;
	localparam int BURST_LEN    = 530;
	localparam int DRAIN_CYCLES = 300;
	localparam int SHOWN_ERRORS = 10;

	// Request codes that the core must ignore.
	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_B = 3'd6;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	timestamped_frame_ring_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the ring state.
	logic [SAMPLE_W-1:0] left_copy  [0:STORE_DEPTH-1];
	logic [SAMPLE_W-1:0] right_copy [0:STORE_DEPTH-1];
	bit                  frame_held [0:STORE_DEPTH-1];
	int                  held_pos[$];
	logic [STAMP_W-1:0]  node_stamp [0:NODES-1];
	logic [NODE_W-1:0]   wr_node;
	logic [NODE_W-1:0]   rd_node;
	logic [FILL_W-1:0]   fill;
	logic [STAMP_W-1:0]  play_base;
	logic [TIMER_W-1:0]  ms_timer;

	rsp_t               pending_replies[$];
	int                 mismatch_count = 0;
	bit                 idle_on        = 1'b1;
	int                 idle_pct       = 20;
	int                 burst_left     = 0;
	logic [STAMP_W-1:0] ms_clock       = '0;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t reply;
	} plan_row_t;

	plan_row_t plan_rows[$];

	// Applies one accepted request beat to the local ring and forms its reply, if any.
	function automatic bit predict_reply(input req_t b, output rsp_t r);
		logic [NODE_W-1:0]  dst;
		logic [FRAME_W-1:0] fsel;
		logic [ALU_W-1:0]   target;
		int                 pos;
		int                 steps;
		bit                 found;
		bit                 made;
		r    = '0;
		made = 1'b0;
		case (b.req_type)
			REQ_SAMPLE: begin
				// Frames past the end of a node are dropped.
				if (fill < FILL_W'(FRAMES)) begin
					dst = (wr_node == NODE_W'(NODES - 1)) ? '0 : wr_node + 1'b1;
					pos = int'(dst) * FRAMES + int'(fill);
					left_copy[pos]  = b.first_value;
					right_copy[pos] = b.is_mono ? b.first_value : b.second_value;
					if (!frame_held[pos]) begin
						frame_held[pos] = 1'b1;
						held_pos.push_back(pos);
					end
					fill = fill + 1'b1;
				end
			end
			REQ_CLOSE: begin
				wr_node             = (wr_node == NODE_W'(NODES - 1)) ? '0 : wr_node + 1'b1;
				node_stamp[wr_node] = b.stamp;
				play_base           = (b.stamp > b.delay) ? b.stamp - b.delay : '0;
				ms_timer            = '0;
				fill                = '0;
			end
			REQ_TICK: begin
				if (ms_timer != '1) begin
					ms_timer = ms_timer + 1'b1;
				end
			end
			REQ_TAKE: begin
				// Step past empty or stale nodes, never more than one lap.
				target = {1'b0, play_base} + ALU_W'(ms_timer);
				steps  = 0;
				found  = 1'b0;
				while (!found && steps < NODES) begin
					if (node_stamp[rd_node] != '0 && {1'b0, node_stamp[rd_node]} >= target) begin
						found = 1'b1;
					end else begin
						rd_node = (rd_node == NODE_W'(NODES - 1)) ? '0 : rd_node + 1'b1;
						steps++;
					end
				end
				r.reply_kind = KIND_TAKE;
				r.out_node   = rd_node;
				r.out_stamp  = node_stamp[rd_node];
				made         = 1'b1;
			end
			REQ_READ: begin
				dst          = NODE_W'(b.node_select % NODES);
				fsel         = FRAME_W'(b.frame_select % FRAMES);
				pos          = int'(dst) * FRAMES + int'(fsel);
				r.reply_kind = KIND_READ;
				r.out_node   = dst;
				r.out_stamp  = node_stamp[dst];
				r.out_left   = left_copy[pos];
				r.out_right  = right_copy[pos];
				made         = 1'b1;
			end
			default: begin
			end
		endcase
		return made;
	endfunction

	function automatic req_t make_beat(input logic [2:0] kind, input logic [31:0] a,
			input logic [31:0] c, input logic mono, input logic [39:0] st,
			input logic [39:0] dl, input logic [6:0] n, input logic [8:0] f);
		req_t b;
		b.req_type     = kind;
		b.first_value  = a;
		b.second_value = c;
		b.is_mono      = mono;
		b.stamp        = st;
		b.delay        = dl;
		b.node_select  = n;
		b.frame_select = f;
		return b;
	endfunction

	function automatic rsp_t make_reply(input logic kind, input logic [6:0] n,
			input logic [39:0] st, input logic [31:0] l, input logic [31:0] rt);
		rsp_t r;
		r.reply_kind = kind;
		r.out_node   = n;
		r.out_stamp  = st;
		r.out_left   = l;
		r.out_right  = rt;
		return r;
	endfunction

	function automatic void add_row(input req_t b, input bit typed, input rsp_t e);
		plan_row_t row;
		row.beat  = b;
		row.typed = typed;
		row.reply = e;
		plan_rows.push_back(row);
	endfunction

	// Directed beats: replies are typed in where they follow directly from the sequence.
	function automatic void build_plan();
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1,
			make_reply(KIND_TAKE, 7'd0, 40'd0, '0, '0));
		add_row(make_beat(REQ_SPARE_A, '1, '1, 1'b1, '1, '1, '1, '1), 1'b0, '0);
		add_row(make_beat(REQ_SPARE_B, '1, '1, 1'b1, '1, '1, '1, '1), 1'b0, '0);
		add_row(make_beat(REQ_SPARE_C, '1, '1, 1'b1, '1, '1, '1, '1), 1'b0, '0);
		add_row(make_beat(REQ_SAMPLE, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, '0, '0, '0, '0),
			1'b0, '0);
		add_row(make_beat(REQ_SAMPLE, 32'h0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_READ, '0, '0, 1'b0, '0, '0, 7'd1, 9'd0), 1'b1,
			make_reply(KIND_READ, 7'd1, 40'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_row(make_beat(REQ_READ, '0, '0, 1'b0, '0, '0, 7'd1, 9'd1), 1'b1,
			make_reply(KIND_READ, 7'd1, 40'd0, 32'h0, 32'hFFFF_FFFF));
		add_row(make_beat(REQ_CLOSE, '0, '0, 1'b0, 40'd100, 40'd40, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_READ, '0, '0, 1'b0, '0, '0, 7'd1, 9'd0), 1'b1,
			make_reply(KIND_READ, 7'd1, 40'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1,
			make_reply(KIND_TAKE, 7'd1, 40'd100, '0, '0));
		repeat (3) add_row(make_beat(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1,
			make_reply(KIND_TAKE, 7'd1, 40'd100, '0, '0));
		// Stamp below the delay: the base drops to zero.
		add_row(make_beat(REQ_CLOSE, '0, '0, 1'b0, 40'd5, 40'd9, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_CLOSE, '0, '0, 1'b0, '1, '1, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_CLOSE, '0, '0, 1'b0, '1, '0, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_TICK, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, '0);
		// Target beyond every stamp: a full lap ends where it began.
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1,
			make_reply(KIND_TAKE, 7'd1, 40'd100, '0, '0));
		add_row(make_beat(REQ_SAMPLE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0, '0, '0, '0),
			1'b0, '0);
		add_row(make_beat(REQ_CLOSE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, '0);
		add_row(make_beat(REQ_READ, '0, '0, 1'b0, '0, '0, 7'd5, 9'd0), 1'b1,
			make_reply(KIND_READ, 7'd5, 40'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
		add_row(make_beat(REQ_TAKE, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1,
			make_reply(KIND_TAKE, 7'd1, 40'd100, '0, '0));
	endfunction

	// Random beat: mostly well-formed audio traffic, reads only of frames already written.
	function automatic req_t random_beat();
		req_t b;
		int   pick;
		int   pos;
		b.first_value  = $urandom();
		b.second_value = $urandom();
		b.is_mono      = 1'($urandom_range(0, 1));
		b.stamp        = STAMP_W'({$urandom(), $urandom()});
		b.delay        = STAMP_W'({$urandom(), $urandom()});
		b.node_select  = 7'($urandom_range(0, 127));
		b.frame_select = 9'($urandom_range(0, 511));
		pick           = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			b.req_type = REQ_SAMPLE;
		end else if (pick < 40) begin
			b.req_type = REQ_SAMPLE;
		end else if (pick < 54) begin
			b.req_type = REQ_CLOSE;
			case ($urandom_range(0, 19))
				0: b.stamp = '0;
				1: b.stamp = STAMP_W'({$urandom(), $urandom()});
				default: begin
					ms_clock = ms_clock + STAMP_W'($urandom_range(1, 40));
					b.stamp  = ms_clock;
				end
			endcase
			if ($urandom_range(0, 9) != 0) begin
				b.delay = STAMP_W'($urandom_range(0, 60));
			end
		end else if (pick < 74) begin
			b.req_type = REQ_TICK;
		end else if (pick < 81) begin
			b.req_type = REQ_TAKE;
		end else if (pick < 97) begin
			b.req_type     = REQ_READ;
			pos            = held_pos[$urandom_range(0, held_pos.size() - 1)];
			b.node_select  = 7'(pos / FRAMES);
			b.frame_select = 9'(pos % FRAMES);
		end else begin
			case ($urandom_range(0, 2))
				0: b.req_type = REQ_SPARE_A;
				1: b.req_type = REQ_SPARE_B;
				default: b.req_type = REQ_SPARE_C;
			endcase
		end
		return b;
	endfunction

	// Presents one request beat from a falling edge and returns at the edge that takes it.
	task automatic send_beat(input req_t beat);
		int gap;
		if (idle_on && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 17);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
	endtask

	// Stimulus, prediction and end of run.
	initial begin : drive_requests
		req_t beat;
		rsp_t reply;
		bit   has_reply;
		for (int n = 0; n < NODES; n++) begin
			node_stamp[n] = '0;
		end
		wr_node   = '0;
		rd_node   = '0;
		fill      = '0;
		play_base = '0;
		ms_timer  = '0;
		build_plan();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (plan_rows[k]) begin
			send_beat(plan_rows[k].beat);
			has_reply = predict_reply(plan_rows[k].beat, reply);
			if (has_reply) begin
				pending_replies.push_back(plan_rows[k].typed ? plan_rows[k].reply : reply);
			end
			@(negedge clk);
		end
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 12;
					default: idle_pct = 35;
				endcase
			end
			idle_on = (i < RANDOM_BEATS - CALM_TAIL);
			// One long run of samples overfills a node.
			if (i == BURST_AT) begin
				burst_left = BURST_LEN;
			end
			beat = random_beat();
			send_beat(beat);
			has_reply = predict_reply(beat, reply);
			if (has_reply) begin
				pending_replies.push_back(reply);
			end
			@(negedge clk);
		end
		idle_on = 1'b0;
		req_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_replies.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Random stall bursts on the reply side.
	initial begin : drive_stall
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
				rsp_stall <= 1'b1;
				hold = $urandom_range(0, 16);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Each reply beat is checked against the oldest prediction.
	always @(posedge clk) begin : check_replies
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS) begin
					$display("unexpected reply beat: kind %0d node %0d stamp %h left %h right %h",
						rsp.reply_kind, rsp.out_node, rsp.out_stamp, rsp.out_left,
						rsp.out_right);
				end
			end else begin
				want = pending_replies.pop_front();
				if (rsp.reply_kind !== want.reply_kind || rsp.out_node !== want.out_node ||
						rsp.out_stamp !== want.out_stamp || rsp.out_left !== want.out_left ||
						rsp.out_right !== want.out_right) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS) begin
						$display("reply mismatch: expected kind %0d node %0d stamp %h left %h right %h",
							want.reply_kind, want.out_node, want.out_stamp, want.out_left,
							want.out_right);
						$display("                got kind %0d node %0d stamp %h left %h right %h",
							rsp.reply_kind, rsp.out_node, rsp.out_stamp, rsp.out_left,
							rsp.out_right);
					end
				end
			end
		end
	end

	// Hard limit on the length of the run.
	initial begin : watchdog
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
